@@ sv/negacyclic_fft_radix2_defines.svh @@
// Assertion macros for the negacyclic transform block.
// Used by the top level; no other dependencies.
`ifndef NEGACYCLIC_FFT_RADIX2_DEFINES_SVH
`define NEGACYCLIC_FFT_RADIX2_DEFINES_SVH
`ifndef SYNTH
`define NFR_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("assertion failed");
`define NFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NFR_ASSERT_NEVER(lbl, cond)
`define NFR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/nfr_pkg.sv @@
// Types, twiddle table and arithmetic helpers for the negacyclic transform.
// No dependencies.
`default_nettype none
package nfr_pkg;
    localparam int TW_DEPTH = 63;
    localparam int TW_AW = 6;
    localparam int TW_LEVELS = 6;
    localparam int DW = 32;
    localparam int WW = 18;
    localparam int AW = 51;

    typedef logic [2*WW-1:0] t_tw_rom [TW_DEPTH];

    function automatic longint unsigned isqrt64(longint unsigned v);
        longint unsigned res;
        longint unsigned bq;
        longint unsigned vv;
        res = 0;
        vv = v;
        bq = 64'd1 << 62;
        while (bq > vv) bq = bq >> 2;
        while (bq != 0) begin
            if (vv >= res + bq) begin
                vv = vv - (res + bq);
                res = (res >> 1) + bq;
            end else begin
                res = res >> 1;
            end
            bq = bq >> 2;
        end
        return res;
    endfunction

    function automatic longint to_q16(longint v);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = (mag + (longint'(1) << 13)) >>> 14;
        return (v < 0) ? -q : q;
    endfunction

    function automatic t_tw_rom build_twiddle_rom();
        longint hr [TW_DEPTH];
        longint hi [TW_DEPTH];
        longint one;
        longint pr;
        longint pi;
        longint ri;
        t_tw_rom rom;
        one = longint'(1) << 30;
        hr[0] = longint'(isqrt64(64'(one) * 64'(one / 2)));
        hi[0] = longint'(isqrt64(64'(one) * 64'(one / 2)));
        for (int p = 0; p < (1 << (TW_LEVELS - 1)) - 1; p++) begin
            pr = hr[p];
            pi = hi[p];
            hr[2*p+1] = longint'(isqrt64(64'(one + pr) * 64'(one / 2)));
            ri = longint'(isqrt64(64'(one - pr) * 64'(one / 2)));
            hi[2*p+1] = (pi < 0) ? -ri : ri;
            hr[2*p+2] = longint'(isqrt64(64'(one - pr) * 64'(one / 2)));
            ri = longint'(isqrt64(64'(one + pr) * 64'(one / 2)));
            hi[2*p+2] = (-pi < 0) ? -ri : ri;
        end
        for (int k = 0; k < TW_DEPTH; k++) begin
            rom[k] = {WW'(to_q16(hr[k])), WW'(to_q16(hi[k]))};
        end
        return rom;
    endfunction

    localparam t_tw_rom TW_ROM = build_twiddle_rom();

    function automatic logic signed [DW-1:0] sat_add(logic signed [DW-1:0] a,
                                                     logic signed [DW-1:0] b,
                                                     logic sub);
        logic signed [DW:0] s;
        s = sub ? (DW+1)'(a) - (DW+1)'(b) : (DW+1)'(a) + (DW+1)'(b);
        if (s[DW] != s[DW-1]) return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return s[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] round_sat(logic signed [AW-1:0] p);
        logic signed [AW-1:0] s;
        logic signed [AW-17:0] q;
        s = p + AW'(32768);
        q = s[AW-1:16];
        if (q > (AW-16)'(64'sd2147483647)) return {1'b0, {(DW-1){1'b1}}};
        if (q < (AW-16)'(-64'sd2147483648)) return {1'b1, {(DW-1){1'b0}}};
        return q[DW-1:0];
    endfunction
endpackage
`default_nettype wire

@@ sv/nfr_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nfr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_a,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

@@ sv/negacyclic_fft_radix2.sv @@
// Load: one item per cycle. After the last load the transform runs
// (POINTS/2) * log2(POINTS) butterflies, each on a single shared 32x18
// multiplier (four partial products per butterfly).
// Emit: each result item is read through store port A and held until taken.
// Synchronous active-low reset clears control state and direction; the
// store content is undefined until loaded.
`default_nettype none
`include "negacyclic_fft_radix2_defines.svh"
module negacyclic_fft_radix2 #(
    parameter int POINTS = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic signed [23:0] i_in_re,
    input  wire logic signed [23:0] i_in_im,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [31:0] o_out_re,
    output logic signed [31:0] o_out_im,
    output logic             o_final_flag
);
    import nfr_pkg::*;

    localparam int LG = $clog2(POINTS);
    localparam int LVW = $clog2(LG);

    typedef enum logic [3:0] {
        S_LOAD, S_ADDR, S_RD, S_CAP, S_MUL, S_WX, S_WY, S_ERD, S_EWAIT, S_EOUT
    } t_state;

    t_state r_state;
    logic r_direction;
    logic [LG-1:0] r_load, r_xa, r_ya;
    logic [LG-2:0] r_j;
    logic [LVW-1:0] r_lev;
    logic [TW_AW-1:0] r_tw;
    logic [1:0] r_mcnt;
    logic signed [DW-1:0] r_xr, r_xi, r_yr, r_yi, r_ar, r_ai, r_tr, r_ti;
    logic signed [WW-1:0] r_wr, r_wi;
    logic signed [AW-1:0] r_acc;

    logic in_acc;
    logic cfg_acc;
    logic ram_we;
    logic [LG-1:0] ram_waddr;
    logic [2*DW-1:0] ram_wdata, rd_a, rd_b;
    logic [LG-1:0] jx, sh_mask, n_xa, n_ya, blk;
    logic [LVW-1:0] sh;
    logic signed [DW-1:0] mul_a;
    logic signed [WW-1:0] mul_b;
    logic signed [AW-1:0] prod;
    logic [2*WW-1:0] tw;
    logic signed [DW-1:0] dr, di;

    assign o_cfg_ready = (r_state == S_LOAD);
    assign cfg_acc = i_cfg_valid && o_cfg_ready;
    assign o_in_ready = (r_state == S_LOAD);
    assign in_acc = i_in_valid && o_in_ready;

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_load;
        ram_wdata = {DW'(i_in_re), DW'(i_in_im)};
        case (r_state)
            S_LOAD: ram_we = in_acc;
            S_WX: begin
                ram_we = 1'b1;
                ram_waddr = r_xa;
                ram_wdata = r_direction ? {sat_add(r_xr, r_yr, 1'b0), sat_add(r_xi, r_yi, 1'b0)}
                                        : {sat_add(r_xr, r_tr, 1'b0), sat_add(r_xi, r_ti, 1'b0)};
            end
            S_WY: begin
                ram_we = 1'b1;
                ram_waddr = r_ya;
                ram_wdata = r_direction ? {r_tr, r_ti}
                                        : {sat_add(r_xr, r_tr, 1'b1), sat_add(r_xi, r_ti, 1'b1)};
            end
            default: ram_we = 1'b0;
        endcase
    end

    nfr_ram #(.WIDTH(2*DW), .DEPTH(POINTS)) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (r_xa),
        .i_raddr_b (r_ya),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_comb begin
        jx = {1'b0, r_j};
        sh = LVW'(LG - 1) - r_lev;
        sh_mask = (LG'(1) << sh) - LG'(1);
        blk = jx >> sh;
        n_xa = ((blk << sh) << 1) | (jx & sh_mask);
        n_ya = n_xa | (LG'(1) << sh);
        tw = TW_ROM[r_tw];
        dr = sat_add(DW'(rd_a[2*DW-1:DW]), DW'(rd_b[2*DW-1:DW]), 1'b1);
        di = sat_add(DW'(rd_a[DW-1:0]), DW'(rd_b[DW-1:0]), 1'b1);
        mul_a = r_mcnt[0] ? r_ai : r_ar;
        mul_b = (r_mcnt[1] ^ r_mcnt[0]) ? r_wi : r_wr;
        prod = AW'(mul_a * mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_direction <= 1'b0;
            r_load <= '0;
            r_j <= '0;
            r_lev <= '0;
            r_mcnt <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (cfg_acc) r_direction <= i_cfg_data;
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        r_load <= r_load + LG'(1);
                        if (r_load == LG'(POINTS - 1)) begin
                            r_j <= '0;
                            r_lev <= (cfg_acc ? i_cfg_data : r_direction) ? LVW'(LG - 1) : '0;
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_ADDR: begin
                    r_xa <= n_xa;
                    r_ya <= n_ya;
                    r_tw <= TW_AW'((7'd1 << r_lev) - 7'd1) + TW_AW'(blk);
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_CAP;
                S_CAP: begin
                    r_xr <= rd_a[2*DW-1:DW];
                    r_xi <= rd_a[DW-1:0];
                    r_yr <= rd_b[2*DW-1:DW];
                    r_yi <= rd_b[DW-1:0];
                    r_ar <= r_direction ? dr : rd_b[2*DW-1:DW];
                    r_ai <= r_direction ? di : rd_b[DW-1:0];
                    r_wr <= tw[2*WW-1:WW];
                    r_wi <= r_direction ? -tw[WW-1:0] : tw[WW-1:0];
                    r_mcnt <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_mcnt <= r_mcnt + 2'd1;
                    case (r_mcnt)
                        2'd0: r_acc <= prod;
                        2'd1: r_tr <= round_sat(r_acc - prod);
                        2'd2: r_acc <= prod;
                        default: begin
                            r_ti <= round_sat(r_acc + prod);
                            r_state <= S_WX;
                        end
                    endcase
                end
                S_WX: r_state <= S_WY;
                S_WY: begin
                    r_j <= r_j + (LG-1)'(1);
                    r_state <= S_ADDR;
                    if (r_j == '1) begin
                        if (r_direction ? (r_lev == '0) : (r_lev == LVW'(LG - 1))) begin
                            r_xa <= '0;
                            r_state <= S_ERD;
                        end else begin
                            r_lev <= r_direction ? r_lev - LVW'(1) : r_lev + LVW'(1);
                        end
                    end
                end
                S_ERD: r_state <= S_EWAIT;
                S_EWAIT: begin
                    o_out_re <= rd_a[2*DW-1:DW];
                    o_out_im <= rd_a[DW-1:0];
                    o_final_flag <= (r_xa == LG'(POINTS - 1));
                    o_out_valid <= 1'b1;
                    r_state <= S_EOUT;
                end
                S_EOUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_xa <= r_xa + LG'(1);
                        r_state <= o_final_flag ? S_LOAD : S_ERD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    `NFR_ASSERT_NEVER(a_no_overlap, o_in_ready && o_out_valid)
    `NFR_ASSERT_NEXT(a_final_returns, o_out_valid && i_out_ready && o_final_flag, o_in_ready)
    `NFR_ASSERT_NEXT(a_last_load_starts, in_acc && (r_load == LG'(POINTS - 1)), !o_in_ready)
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for negacyclic_fft_radix2 (POINTS = 64).
// Predicts each transformed block in fixed point and checks it item by item.
// Depends on the negacyclic_fft_radix2 RTL and its package.
`default_nettype none
module tb_top;
    localparam int NPTS = 64;
    localparam int NLEV = 6;
    localparam int NTW = 63;
    localparam longint UNIT = longint'(1) << 30;
    localparam int WATCH_LIMIT = 40000;

    typedef struct packed {
        logic signed [23:0] re;
        logic signed [23:0] im;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
    } t_point;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    logic signed [23:0] i_in_re;
    logic signed [23:0] i_in_im;
    logic o_out_valid;
    logic i_out_ready;
    logic signed [31:0] o_out_re;
    logic signed [31:0] o_out_im;
    logic o_final_flag;

    negacyclic_fft_radix2 #(.POINTS(NPTS)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_re     (i_in_re),
        .i_in_im     (i_in_im),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im),
        .o_final_flag(o_final_flag)
    );

    t_sample pending_samples[$];
    t_point  expected_points[$];
    longint  tw_re[NTW];
    longint  tw_im[NTW];
    longint  buf_re[NPTS];
    longint  buf_im[NPTS];
    int      fill_count;
    logic    inverse_mode;
    logic    in_fire;
    int      n_in;
    int      n_out;
    int      quiet_cycles;
    int      errors;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned probe;
        root = 0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint scale_q16(longint v);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (longint'(1) << 13)) >>> 14;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint round_q16(longint p);
        return clamp32((p + (longint'(1) << 15)) >>> 16);
    endfunction

    task automatic build_twiddles();
        longint hr[NTW];
        longint hi[NTW];
        longint mag;
        int p;
        int c;
        hr[0] = longint'(int_sqrt(64'(UNIT) * 64'(UNIT / 2)));
        hi[0] = hr[0];
        for (int lev = 0; lev + 1 < NLEV; lev++) begin
            for (int b = 0; b < (1 << lev); b++) begin
                p = (1 << lev) - 1 + b;
                c = (2 << lev) - 1 + 2 * b;
                hr[c] = longint'(int_sqrt(64'(UNIT + hr[p]) * 64'(UNIT / 2)));
                mag = longint'(int_sqrt(64'(UNIT - hr[p]) * 64'(UNIT / 2)));
                hi[c] = (hi[p] < 0) ? -mag : mag;
                hr[c+1] = longint'(int_sqrt(64'(UNIT - hr[p]) * 64'(UNIT / 2)));
                mag = longint'(int_sqrt(64'(UNIT + hr[p]) * 64'(UNIT / 2)));
                hi[c+1] = (-hi[p] < 0) ? -mag : mag;
            end
        end
        for (int k = 0; k < NTW; k++) begin
            tw_re[k] = scale_q16(hr[k]);
            tw_im[k] = scale_q16(hi[k]);
        end
    endtask

    task automatic transform_block();
        int n;
        int m;
        int lev;
        int idx;
        longint wr;
        longint wi;
        longint xr;
        longint xi;
        longint yr;
        longint yi;
        longint tr;
        longint ti;
        for (int k = 0; k < NLEV; k++) begin
            lev = inverse_mode ? NLEV - 1 - k : k;
            n = NPTS >> lev;
            m = n / 2;
            for (int b = 0; b < (1 << lev); b++) begin
                idx = (1 << lev) - 1 + b;
                wr = tw_re[idx];
                wi = inverse_mode ? -tw_im[idx] : tw_im[idx];
                for (int i = b * n; i < b * n + m; i++) begin
                    xr = buf_re[i];
                    xi = buf_im[i];
                    yr = buf_re[i+m];
                    yi = buf_im[i+m];
                    if (inverse_mode) begin
                        tr = clamp32(xr - yr);
                        ti = clamp32(xi - yi);
                        buf_re[i] = clamp32(xr + yr);
                        buf_im[i] = clamp32(xi + yi);
                        buf_re[i+m] = round_q16(tr * wr - ti * wi);
                        buf_im[i+m] = round_q16(tr * wi + ti * wr);
                    end else begin
                        tr = round_q16(yr * wr - yi * wi);
                        ti = round_q16(yr * wi + yi * wr);
                        buf_re[i+m] = clamp32(xr - tr);
                        buf_im[i+m] = clamp32(xi - ti);
                        buf_re[i] = clamp32(xr + tr);
                        buf_im[i] = clamp32(xi + ti);
                    end
                end
            end
        end
    endtask

    task automatic load_sample(logic signed [23:0] re, logic signed [23:0] im);
        t_point pt;
        buf_re[fill_count] = longint'(re);
        buf_im[fill_count] = longint'(im);
        fill_count++;
        if (fill_count == NPTS) begin
            fill_count = 0;
            transform_block();
            for (int k = 0; k < NPTS; k++) begin
                pt.re = buf_re[k][31:0];
                pt.im = buf_im[k][31:0];
                pt.last = (k == NPTS - 1);
                expected_points.push_back(pt);
            end
        end
    endtask

    function automatic int stall_mode();
        return ((n_in + n_out) / 40) % 4;
    endfunction

    // monitor and predictor
    always @(posedge i_clk) begin
        t_point exp_pt;
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
                (o_out_valid && i_out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (i_cfg_valid && o_cfg_ready) begin
                inverse_mode = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                load_sample(i_in_re, i_in_im);
                n_in++;
            end
            if (o_out_valid && i_out_ready) begin
                n_out++;
                if (expected_points.size() == 0) begin
                    $error("unexpected item: re=%0d im=%0d", o_out_re, o_out_im);
                    errors++;
                end else begin
                    exp_pt = expected_points.pop_front();
                    if (o_out_re !== exp_pt.re) begin
                        $error("out_re: expected %0d, got %0d", exp_pt.re, o_out_re);
                        errors++;
                    end
                    if (o_out_im !== exp_pt.im) begin
                        $error("out_im: expected %0d, got %0d", exp_pt.im, o_out_im);
                        errors++;
                    end
                    if (o_final_flag !== exp_pt.last) begin
                        $error("final_flag: expected %0d, got %0d", exp_pt.last,
                               o_final_flag);
                        errors++;
                    end
                end
            end
        end
    end

    // driver
    always @(negedge i_clk) begin
        t_sample s;
        int mode;
        mode = stall_mode();
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_ready <= 1'b0;
        end else begin
            if (mode == 2)
                i_out_ready <= ($urandom_range(99) >= 65);
            else if (mode == 3)
                i_out_ready <= ($urandom_range(99) >= 7);
            else
                i_out_ready <= 1'b1;
            if (!i_in_valid || in_fire) begin
                if (pending_samples.size() != 0 &&
                    !(mode == 1 && $urandom_range(99) < 65) &&
                    !(mode == 3 && $urandom_range(99) < 7)) begin
                    s = pending_samples.pop_front();
                    i_in_valid <= 1'b1;
                    i_in_re <= s.re;
                    i_in_im <= s.im;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic write_direction(logic dir);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= dir;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_in_valid && expected_points.size() == 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic queue_block(bit with_extremes);
        t_sample s;
        logic signed [23:0] corner[6];
        corner = '{24'sh7FFFFF, -24'sh800000, 24'sh000000, 24'sh555555,
                   -24'sh555556, 24'sh000001};
        for (int k = 0; k < NPTS; k++) begin
            if (with_extremes && k < 24) begin
                s.re = corner[k % 6];
                s.im = corner[(k / 6 + k) % 6];
            end else if ($urandom_range(3) == 0) begin
                s.re = $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
                s.im = $urandom_range(1) ? 24'sh7FFFFF : -24'sh800000;
            end else begin
                s.re = 24'($urandom);
                s.im = 24'($urandom);
            end
            pending_samples.push_back(s);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 1'b0;
        i_in_valid = 1'b0;
        i_in_re = '0;
        i_in_im = '0;
        i_out_ready = 1'b0;
        in_fire = 1'b0;
        fill_count = 0;
        inverse_mode = 1'b0;
        n_in = 0;
        n_out = 0;
        quiet_cycles = 0;
        errors = 0;
        build_twiddles();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_direction(1'b0);
        queue_block(1'b1);
        drain();
        write_direction(1'b0);
        write_direction(1'b1);
        queue_block(1'b1);
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        wait (quiet_cycles >= WATCH_LIMIT);
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+sv
sv/nfr_pkg.sv
sv/nfr_ram.sv
sv/negacyclic_fft_radix2.sv
test/tb_top.sv
